// ----- design/pms_pkg.sv -----
// Shared types, constants and codes for the periodic message scheduler.
// Depends on nothing; every other design file but pms_ram refers to it by scoped names.
package pms_pkg;

	localparam int NUM_SLOTS   = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_DUE_MARGIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT       = 2'd2;

	localparam logic [15:0] DUE_MARGIN_RST     = 16'd3;
	localparam logic [31:0] OVERFLOW_LIMIT_RST = 32'd60000;
	localparam logic [15:0] MAX_WAIT_RST       = 16'd5000;

	localparam logic [0:0] KIND_REG  = 1'b0;
	localparam logic [0:0] KIND_SCAN = 1'b1;

	localparam logic [7:0] EN_OFF = 8'd0;
	localparam logic [7:0] EN_ON  = 8'd1;

	localparam logic [1:0] RK_ACK = 2'd0;
	localparam logic [1:0] RK_DUE = 2'd1;
	localparam logic [1:0] RK_END = 2'd2;

	typedef struct packed {
		logic [0:0]  kind;
		logic [7:0]  msg_id;
		logic [15:0] period;
		logic [7:0]  enable;
		logic [31:0] now_time;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  due_id;
		logic [15:0] wait_time;
		logic [0:0]  error;
		logic [0:0]  last;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_ON,
		OP_OFF,
		OP_BAD,
		OP_SCAN
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  msg_id;
		logic [15:0] period;
		logic [31:0] now_time;
	} cmd_t;

	typedef struct packed {
		logic [15:0] due_margin;
		logic [31:0] overflow_limit;
		logic [15:0] max_wait;
	} cfg_t;

endpackage

// ----- design/pms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/pms_front.sv -----
// Front end: accepts request items, classifies them into commands and
// offers them to the command queue. Depends on pms_pkg.
module pms_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pms_pkg::req_t req_data,
	output logic          push_valid,
	input  logic          push_ready,
	output pms_pkg::cmd_t push_cmd
);

	logic          valid_s1;
	pms_pkg::cmd_t cmd_s1;
	pms_pkg::op_t  op;

	always_comb begin
		priority if (req_data.kind == pms_pkg::KIND_SCAN) begin
			op = pms_pkg::OP_SCAN;
		end else if (req_data.enable == pms_pkg::EN_ON) begin
			op = pms_pkg::OP_ON;
		end else if (req_data.enable == pms_pkg::EN_OFF) begin
			op = pms_pkg::OP_OFF;
		end else begin
			op = pms_pkg::OP_BAD;
		end
	end

	assign req_ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_s1 <= '{op: op, msg_id: req_data.msg_id, period: req_data.period,
				now_time: req_data.now_time};
		end
	end

endmodule

// ----- design/pms_queue.sv -----
// Short command queue between front and back end.
// Depends on pms_pkg.
module pms_queue #(
	parameter int DEPTH = pms_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pms_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output pms_pkg::cmd_t out_cmd
);

	localparam int PtrW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

	pms_pkg::cmd_t   mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	assign in_ready  = count_q != Full;
	assign out_valid = count_q != '0;
	assign out_cmd   = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

// ----- design/pms_back.sv -----
// Back end: walks the slot table one slot a cycle for each command but a bad one, stalling
// while a due item waits on the output; emits acknowledge, due and end-of-scan items. Depends on pms_pkg, pms_ram.
module pms_back #(
	parameter int NUM_SLOTS = pms_pkg::NUM_SLOTS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pms_pkg::cfg_t cfg,
	input  logic          q_valid,
	output logic          q_ready,
	input  pms_pkg::cmd_t q_cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pms_pkg::rsp_t rsp_data
);

	localparam int IdxW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DONE
	} state_t;

	state_t          state_q;
	pms_pkg::cmd_t   cmd_q;
	logic [IdxW-1:0] idx_q;
	logic [15:0]     wait_q;
	logic            err_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] idp_wr_q;
	logic [NUM_SLOTS-1:0] ls_wr_q;
	logic            rsp_valid_q;
	pms_pkg::rsp_t   rsp_q;

	logic [IdxW-1:0] raddr;
	logic [23:0]     idp_rdata;
	logic [31:0]     ls_rdata;
	logic            idp_we;
	logic            ls_we;

	logic        out_free;
	logic        last_slot;
	logic        is_scan;
	logic        act;
	logic [7:0]  id_v;
	logic [15:0] per_v;
	logic [31:0] ls_v;
	logic [31:0] rem;
	logic        due_emit;
	logic        hit;
	logic        advance;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign last_slot = idx_q == LastIdx;
	assign is_scan   = cmd_q.op == pms_pkg::OP_SCAN;
	assign act       = active_q[idx_q];
	assign id_v      = idp_wr_q[idx_q] ? idp_rdata[23:16] : 8'd0;
	assign per_v     = idp_wr_q[idx_q] ? idp_rdata[15:0] : 16'd0;
	assign ls_v      = ls_wr_q[idx_q] ? ls_rdata : 32'd0;
	assign rem       = ls_v + {16'd0, per_v} - cmd_q.now_time;
	assign due_emit  = is_scan && act &&
		((rem < {16'd0, cfg.due_margin}) || (rem > cfg.overflow_limit));
	assign hit       = (cmd_q.op == pms_pkg::OP_ON) ? !act : (id_v == cmd_q.msg_id);
	assign advance   = (state_q == S_WALK) && (!due_emit || out_free);
	assign idp_we    = (state_q == S_WALK) && (cmd_q.op == pms_pkg::OP_ON) && hit;
	assign ls_we     = advance && due_emit;
	assign q_ready   = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		unique case (state_q)
			S_IDLE: raddr = '0;
			S_WALK: raddr = (advance && !last_slot) ? idx_q + IdxW'(1) : idx_q;
			default: raddr = idx_q;
		endcase
	end

	pms_ram #(.WIDTH(24), .DEPTH(NUM_SLOTS)) u_idp_ram (
		.clk   (clk),
		.we    (idp_we),
		.waddr (idx_q),
		.wdata ({cmd_q.msg_id, cmd_q.period}),
		.raddr (raddr),
		.rdata (idp_rdata)
	);

	pms_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_ls_ram (
		.clk   (clk),
		.we    (ls_we),
		.waddr (idx_q),
		.wdata (cmd_q.now_time),
		.raddr (raddr),
		.rdata (ls_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			active_q    <= '0;
			idp_wr_q    <= '0;
			ls_wr_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q   <= q_cmd;
						idx_q   <= '0;
						wait_q  <= cfg.max_wait;
						err_q   <= 1'b1;
						state_q <= (q_cmd.op == pms_pkg::OP_BAD) ? S_DONE : S_WALK;
					end
				end
				S_WALK: begin
					if (advance) begin
						if (is_scan) begin
							if (due_emit) begin
								rsp_valid_q <= 1'b1;
								rsp_q <= '{result_kind: pms_pkg::RK_DUE, due_id: id_v,
									wait_time: 16'd0, error: 1'b0, last: 1'b0};
								ls_wr_q[idx_q] <= 1'b1;
								if (per_v < wait_q) begin
									wait_q <= per_v;
								end
							end else if (act && (rem < {16'd0, wait_q})) begin
								wait_q <= rem[15:0];
							end
							if (last_slot) begin
								state_q <= S_DONE;
							end else begin
								idx_q <= idx_q + IdxW'(1);
							end
						end else if (hit) begin
							err_q   <= 1'b0;
							state_q <= S_DONE;
							if (cmd_q.op == pms_pkg::OP_ON) begin
								active_q[idx_q] <= 1'b1;
								idp_wr_q[idx_q] <= 1'b1;
							end else begin
								active_q[idx_q] <= 1'b0;
							end
						end else if (last_slot) begin
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + IdxW'(1);
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						if (is_scan) begin
							rsp_q <= '{result_kind: pms_pkg::RK_END, due_id: 8'd0,
								wait_time: wait_q, error: 1'b0, last: 1'b1};
						end else begin
							rsp_q <= '{result_kind: pms_pkg::RK_ACK, due_id: 8'd0,
								wait_time: 16'd0, error: err_q, last: 1'b1};
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- design/periodic_message_scheduler.sv -----
// Periodic message scheduler top level: configuration registers, front end,
// command queue and back end. Depends on pms_pkg, pms_front, pms_queue, pms_back.
// Flow: the front end registers each item towards the command queue; the back end takes
// a command only when idle and, unless it is bad, walks the slots one per cycle, pausing
// while a due item waits on the output; a later command waits in the queue meanwhile.
// Reset: asynchronous, clears all slot flags and loads the register defaults at once.
module periodic_message_scheduler #(
	parameter int NUM_SLOTS   = pms_pkg::NUM_SLOTS,
	parameter int QUEUE_DEPTH = pms_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  pms_pkg::req_t                  req_data,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output pms_pkg::rsp_t                  rsp_data,
	input  logic                           cfg_we,
	input  logic [pms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pms_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	pms_pkg::cfg_t cfg_q;
	logic          push_valid;
	logic          push_ready;
	pms_pkg::cmd_t push_cmd;
	logic          q_valid;
	logic          q_ready;
	pms_pkg::cmd_t q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{due_margin: pms_pkg::DUE_MARGIN_RST,
				overflow_limit: pms_pkg::OVERFLOW_LIMIT_RST,
				max_wait: pms_pkg::MAX_WAIT_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				pms_pkg::CFG_DUE_MARGIN:     cfg_q.due_margin     <= cfg_wdata[15:0];
				pms_pkg::CFG_OVERFLOW_LIMIT: cfg_q.overflow_limit <= cfg_wdata[31:0];
				pms_pkg::CFG_MAX_WAIT:       cfg_q.max_wait       <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	pms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_data   (req_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	pms_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_cmd    (push_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	pms_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

// ----- design/pms_checker.sv -----
// Port-level checks for the periodic message scheduler, bound to the top level.
// Depends on pms_pkg and periodic_message_scheduler.
module pms_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input pms_pkg::rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response item changed before it was taken");

	a_ack_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.result_kind == pms_pkg::RK_ACK) |->
		rsp_data.last && (rsp_data.due_id == 8'd0) && (rsp_data.wait_time == 16'd0))
		else $error("malformed acknowledge item");

	a_scan_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.result_kind != pms_pkg::RK_ACK) |->
		!rsp_data.error &&
		(((rsp_data.result_kind == pms_pkg::RK_DUE) && !rsp_data.last &&
		(rsp_data.wait_time == 16'd0)) ||
		((rsp_data.result_kind == pms_pkg::RK_END) && rsp_data.last &&
		(rsp_data.due_id == 8'd0))))
		else $error("malformed scan item");

	a_reset_quiet: assert property (@(posedge clk) $rose(arst_n) |-> !rsp_valid)
		else $error("response valid during reset");

endmodule

bind periodic_message_scheduler pms_checker u_pms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);

// ----- verif/tb_periodic_message_scheduler.sv -----
// Self-checking testbench for periodic_message_scheduler: subscribe, unsubscribe and scan
// items checked against an in-bench schedule tracker, under idling and back-pressure.
// Depends on pms_pkg and the periodic_message_scheduler RTL.
module tb_periodic_message_scheduler;
	import pms_pkg::*;

	localparam int                   QUIET_LIMIT = 2000;
	localparam int                   HOLD_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req_data  = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	periodic_message_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// schedule tracker state
	bit   [15:0] margin_cfg     = DUE_MARGIN_RST;
	bit   [31:0] late_limit_cfg = OVERFLOW_LIMIT_RST;
	bit   [15:0] wait_cap_cfg   = MAX_WAIT_RST;
	bit          slot_on    [NUM_SLOTS];
	bit   [7:0]  slot_msg   [NUM_SLOTS];
	bit   [15:0] slot_per   [NUM_SLOTS];
	bit   [31:0] slot_stamp [NUM_SLOTS];
	rsp_t        sched_out_q[$];

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_len      = 0;
	int          hold_token    = 0;
	int          hold_seen     = 0;
	int          hold_left     = 0;
	int          quiet_cycles  = 0;
	int          mismatches    = 0;
	int          items_sent    = 0;
	int          scans_sent    = 0;
	int          results_seen  = 0;
	int          due_seen      = 0;
	logic [31:0] tick_now      = '0;
	rsp_t        head_result;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic run_schedule(req_t it);
		rsp_t        r;
		logic [31:0] rem;
		logic [31:0] wait_left;
		bit          found;
		if (it.kind == KIND_REG) begin
			found = 1'b0;
			for (int i = 0; i < NUM_SLOTS && !found; i++) begin
				if (it.enable == EN_ON && !slot_on[i]) begin
					slot_on[i]  = 1'b1;
					slot_msg[i] = it.msg_id;
					slot_per[i] = it.period;
					found       = 1'b1;
				end else if (it.enable == EN_OFF && slot_msg[i] == it.msg_id) begin
					slot_on[i] = 1'b0;
					found      = 1'b1;
				end
			end
			r             = '0;
			r.result_kind = RK_ACK;
			r.error       = !found;
			r.last        = 1'b1;
			sched_out_q.push_back(r);
		end else begin
			wait_left = {16'h0000, wait_cap_cfg};
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (slot_on[i]) begin
					rem = slot_stamp[i] + {16'h0000, slot_per[i]} - it.now_time;
					if (rem < {16'h0000, margin_cfg} || rem > late_limit_cfg) begin
						slot_stamp[i] = it.now_time;
						r             = '0;
						r.result_kind = RK_DUE;
						r.due_id      = slot_msg[i];
						sched_out_q.push_back(r);
						if ({16'h0000, slot_per[i]} < wait_left)
							wait_left = {16'h0000, slot_per[i]};
					end else if (rem < wait_left) begin
						wait_left = rem;
					end
				end
			end
			r             = '0;
			r.result_kind = RK_END;
			r.wait_time   = wait_left[15:0];
			r.last        = 1'b1;
			sched_out_q.push_back(r);
		end
	endtask

	function automatic req_t build_item(op_t op, logic [7:0] id, logic [15:0] per,
			logic [31:0] now);
		req_t it;
		it.kind     = KIND_REG;
		it.msg_id   = 8'($urandom);
		it.period   = 16'($urandom);
		it.enable   = 8'($urandom);
		it.now_time = $urandom;
		case (op)
			OP_ON: begin
				it.msg_id = id;
				it.period = per;
				it.enable = EN_ON;
			end
			OP_OFF: begin
				it.msg_id = id;
				it.enable = EN_OFF;
			end
			OP_BAD: it.enable = 8'($urandom_range(255, 2));
			default: begin
				it.kind     = KIND_SCAN;
				it.now_time = now;
			end
		endcase
		return it;
	endfunction

	task automatic send_item(req_t item);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		run_schedule(item);
		items_sent++;
		if (item.kind == KIND_SCAN)
			scans_sent++;
	endtask

	task automatic settle_block();
		req_valid <= 1'b0;
		while (sched_out_q.size() != 0) @(posedge clk);
		repeat (NUM_SLOTS + 6) @(posedge clk);
	endtask

	task automatic cfg_apply(logic [15:0] margin, logic [31:0] limit, logic [15:0] cap);
		logic [31:0] junk;
		junk = $urandom;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DUE_MARGIN;
		cfg_wdata <= {junk[31:16], margin};
		@(posedge clk);
		cfg_index <= CFG_OVERFLOW_LIMIT;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_index <= CFG_MAX_WAIT;
		cfg_wdata <= {junk[15:0], cap};
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_wdata <= $urandom;
		@(posedge clk);
		cfg_we         <= 1'b0;
		margin_cfg     = margin;
		late_limit_cfg = limit;
		wait_cap_cfg   = cap;
	endtask

	task automatic test_directed();
		req_t        it;
		logic [7:0]  id;
		logic [15:0] per;
		send_item(build_item(OP_SCAN, 8'h00, 16'h0000, $urandom));
		send_item(build_item(OP_OFF, 8'h00, 16'h0000, 32'h0));
		send_item(build_item(OP_OFF, 8'h77, 16'h0000, 32'h0));
		it        = build_item(OP_BAD, 8'h00, 16'h0000, 32'h0);
		it.enable = 8'hFF;
		send_item(it);
		it        = build_item(OP_BAD, 8'h00, 16'h0000, 32'h0);
		it.enable = 8'h02;
		send_item(it);
		for (int i = 0; i < NUM_SLOTS; i++) begin
			id  = (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'(i * 13 + 5);
			per = (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom_range(2000, 1));
			send_item(build_item(OP_ON, id, per, 32'h0));
		end
		send_item(build_item(OP_ON, 8'h55, 16'd10, 32'h0));
		send_item(build_item(OP_SCAN, 8'h00, 16'h0000, 32'hFFFF_FFFF));
		send_item(build_item(OP_SCAN, 8'h00, 16'h0000, 32'h0000_0000));
		send_item(build_item(OP_OFF, 8'(6 * 13 + 5), 16'h0000, 32'h0));
		send_item(build_item(OP_OFF, 8'(6 * 13 + 5), 16'h0000, 32'h0));
		send_item(build_item(OP_ON, 8'hA5, 16'd100, 32'h0));
	endtask

	task automatic test_config_extremes();
		send_idle_pct = 11;
		recv_idle_pct = 66;
		settle_block();
		cfg_apply(16'h0000, 32'hFFFF_FFFF, 16'h0000);
		repeat (3) begin
			tick_now += $urandom_range(3000, 0);
			send_item(build_item(OP_SCAN, 8'h00, 16'h0000, tick_now));
		end
		settle_block();
		cfg_apply(16'hFFFF, 32'h0000_0000, 16'hFFFF);
		repeat (3) begin
			tick_now += $urandom_range(3000, 0);
			send_item(build_item(OP_SCAN, 8'h00, 16'h0000, tick_now));
		end
	endtask

	task automatic test_random_traffic(int count, int s_idle, int r_idle);
		int          sel;
		logic [7:0]  id;
		logic [15:0] per;
		settle_block();
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		cfg_apply(16'($urandom_range(40, 0)), $urandom_range(100000, 3000), 16'($urandom));
		repeat (count) begin
			sel = $urandom_range(99, 0);
			id  = ($urandom_range(99, 0) < 80) ? 8'h40 + 8'($urandom_range(19, 0)) : 8'($urandom);
			case ($urandom_range(19, 0))
				0:       per = 16'h0000;
				1:       per = 16'hFFFF;
				2:       per = 16'($urandom);
				default: per = 16'($urandom_range(3000, 1));
			endcase
			if (sel < 60) begin
				case ($urandom_range(19, 0))
					0:       tick_now = $urandom;
					1:       tick_now += $urandom_range(200000, 60000);
					default: tick_now += $urandom_range(1500, 0);
				endcase
				send_item(build_item(OP_SCAN, id, per, tick_now));
			end else if (sel < 80) begin
				send_item(build_item(OP_ON, id, per, tick_now));
			end else if (sel < 96) begin
				send_item(build_item(OP_OFF, id, per, tick_now));
			end else begin
				send_item(build_item(OP_BAD, id, per, tick_now));
			end
		end
	endtask

	task automatic test_backpressure();
		settle_block();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (NUM_SLOTS)
			send_item(build_item(OP_ON, 8'($urandom), 16'($urandom_range(3000, 1)), 32'h0));
		hold_len   = HOLD_CYCLES;
		hold_token = hold_token + 1;
		repeat (10) begin
			tick_now += 32'h1000_0000;
			send_item(build_item(OP_SCAN, 8'h00, 16'h0000, tick_now));
		end
		settle_block();
		repeat (6) begin
			tick_now += $urandom_range(1500, 0);
			send_item(build_item(OP_SCAN, 8'h00, 16'h0000, tick_now));
		end
	endtask

	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= hold_len;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			results_seen++;
			if (sched_out_q.size() == 0) begin
				$error("result with nothing pending: %h", rsp_data);
				mismatches++;
			end else begin
				head_result = sched_out_q.pop_front();
				if (head_result.result_kind == RK_DUE)
					due_seen++;
				check_field("result_kind", 32'(head_result.result_kind),
					32'(rsp_data.result_kind));
				check_field("due_id", 32'(head_result.due_id), 32'(rsp_data.due_id));
				check_field("wait_time", 32'(head_result.wait_time),
					32'(rsp_data.wait_time));
				check_field("error", 32'(head_result.error), 32'(rsp_data.error));
				check_field("last", 32'(head_result.last), 32'(rsp_data.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
			$display("tb_periodic_message_scheduler failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random_traffic(100, 11, 66);
		test_random_traffic(100, 66, 11);
		test_random_traffic(85, 0, 0);
		test_backpressure();
		settle_block();
		repeat (NUM_SLOTS + 8) @(posedge clk);
		if (sched_out_q.size() != 0)
			$error("%0d results never arrived", sched_out_q.size());
		$display("sent %0d items (%0d scans); checked %0d results, %0d due notices",
			items_sent, scans_sent, results_seen, due_seen);
		$display("covered reset, extreme and random settings, swapped idling, long hold-off");
		if (mismatches == 0 && sched_out_q.size() == 0)
			$display("tb_periodic_message_scheduler passed");
		else
			$display("tb_periodic_message_scheduler failed");
		$finish;
	end

endmodule
